// ===== sv/sts_pkg.sv =====
// shared types, constants and helpers for the secant threshold search
// used by sts_ctrl, sts_dpath, secant_threshold_search and sts_checker
package sts_pkg;

  localparam int LEVEL_BITS  = 32;
  localparam int ERR_BITS    = 31;
  localparam int ITER_BITS   = 10;
  localparam int MAG_BITS    = LEVEL_BITS + 1;
  localparam int PROD_BITS   = 2 * MAG_BITS;
  localparam int QUOT_BITS   = LEVEL_BITS + 2;
  localparam int MUL_STEPS   = MAG_BITS;
  localparam int DIV_STEPS   = QUOT_BITS;
  localparam int CNT_BITS    = 6;
  localparam int IN_BYTES    = 5;
  localparam int OUT_BYTES   = 8;
  localparam int ADDR_BITS   = 4;
  localparam int DATA_BITS   = 32;

  localparam logic [ERR_BITS-1:0]   ACC_RESET   = ERR_BITS'(6554);
  localparam logic [ITER_BITS-1:0]  ITER_RESET  = ITER_BITS'(20);
  localparam logic [LEVEL_BITS-1:0] GUESS_RESET = LEVEL_BITS'(6553600);
  localparam logic [6:0]            SCALE_MUL   = 7'd101;
  localparam logic [6:0]            SCALE_BIAS  = 7'd50;
  localparam logic [6:0]            SCALE_DIV   = 7'd100;
  localparam logic [MAG_BITS-1:0]   STEP_LIMIT  = {1'b1, {LEVEL_BITS{1'b0}}};

  typedef enum logic [1:0] {
    REG_TARGET_LEVEL = 2'd0,
    REG_TARGET_ACC   = 2'd1,
    REG_MAX_ITER     = 2'd2,
    REG_INIT_GUESS   = 2'd3
  } reg_idx_t;

  typedef enum logic {
    OP_START   = 1'b0,
    OP_MEASURE = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    ST_REQUEST = 2'd0,
    ST_FOUND   = 2'd1,
    ST_GAVE_UP = 2'd2,
    ST_ERROR   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_FIRST  = 2'd1,
    PH_SEARCH = 2'd2
  } phase_t;

  typedef enum logic [2:0] {
    K_ERR        = 3'd0,
    K_FIRST      = 3'd1,
    K_BEGIN      = 3'd2,
    K_BEGIN_MEAS = 3'd3,
    K_FOUND      = 3'd4,
    K_STEP       = 3'd5
  } kind_t;

  typedef struct packed {
    logic [LEVEL_BITS-1:0] target_level;
    logic [ERR_BITS-1:0]   target_accuracy;
    logic [ITER_BITS-1:0]  max_iterations;
    logic [LEVEL_BITS-1:0] initial_guess;
  } cfg_t;

  typedef struct packed {
    logic  load;
    logic  init_mul;
    logic  mul_step;
    logic  add;
    logic  div_step;
    logic  commit;
    kind_t kind;
  } cmd_t;

  typedef struct packed {
    logic   opcode;
    logic   first_pass;
    logic   model_failed;
    logic   acc_zero;
    phase_t phase;
    logic   found;
    logic   dx_zero;
    logic   dy_zero;
    logic   mul_done;
    logic   div_done;
    logic   out_free;
  } stat_t;

  // clamp a widened level back into the signed level range
  function automatic logic [LEVEL_BITS-1:0] sat_level(input logic signed [QUOT_BITS-1:0] x);
    logic signed [QUOT_BITS-1:0] hi;
    logic signed [QUOT_BITS-1:0] lo;
    hi = QUOT_BITS'({1'b0, {(LEVEL_BITS-1){1'b1}}});
    lo = -hi - QUOT_BITS'(1);
    if (x > hi) return hi[LEVEL_BITS-1:0];
    else if (x < lo) return lo[LEVEL_BITS-1:0];
    else return x[LEVEL_BITS-1:0];
  endfunction

endpackage

// ===== sv/sts_ctrl.sv =====
// controller state machine of the secant threshold search
// depends on sts_pkg; drives sts_dpath through cmd_t and reads stat_t
module sts_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  sts_pkg::stat_t  stat,
  output sts_pkg::cmd_t   cmd
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_DECODE = 6'b000010,
    S_MUL    = 6'b000100,
    S_ADD    = 6'b001000,
    S_DIV    = 6'b010000,
    S_EMIT   = 6'b100000
  } state_t;

  state_t        state, state_next;
  sts_pkg::kind_t kind, kind_dec;
  logic          need_arith;

  // classify the request from the latched item and the search state
  always_comb begin
    kind_dec = sts_pkg::K_ERR;
    if (stat.opcode == sts_pkg::OP_START) begin
      if (stat.acc_zero) kind_dec = sts_pkg::K_ERR;
      else if (stat.first_pass) kind_dec = sts_pkg::K_FIRST;
      else kind_dec = sts_pkg::K_BEGIN;
    end else begin
      if (stat.phase == sts_pkg::PH_IDLE || stat.model_failed) kind_dec = sts_pkg::K_ERR;
      else if (stat.phase == sts_pkg::PH_FIRST) kind_dec = sts_pkg::K_BEGIN_MEAS;
      else if (stat.found) kind_dec = sts_pkg::K_FOUND;
      else kind_dec = sts_pkg::K_STEP;
    end
    need_arith = (kind_dec == sts_pkg::K_BEGIN) || (kind_dec == sts_pkg::K_BEGIN_MEAS) ||
                 (kind_dec == sts_pkg::K_STEP && !stat.dx_zero && !stat.dy_zero);
  end

  // next state and commands
  always_comb begin
    state_next   = state;
    cmd          = '0;
    cmd.kind     = kind;
    unique case (state)
      S_IDLE: begin
        cmd.load = in_valid;
        if (in_valid) state_next = S_DECODE;
      end
      S_DECODE: begin
        cmd.kind = kind_dec;
        if (need_arith) begin
          cmd.init_mul = 1'b1;
          state_next   = S_MUL;
        end else begin
          state_next = S_EMIT;
        end
      end
      S_MUL: begin
        cmd.mul_step = 1'b1;
        if (stat.mul_done) state_next = S_ADD;
      end
      S_ADD: begin
        cmd.add    = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_done) state_next = S_EMIT;
      end
      S_EMIT: begin
        cmd.commit = stat.out_free;
        if (stat.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state and request kind registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      kind  <= sts_pkg::K_ERR;
    end else begin
      state <= state_next;
      if (state == S_DECODE) kind <= kind_dec;
    end
  end

  assign in_ready = (state == S_IDLE);

endmodule

// ===== sv/sts_dpath.sv =====
// datapath of the secant threshold search: search state, shift-add
// multiplier, restoring divider and output register; depends on sts_pkg
module sts_dpath (
  input  logic                           clk,
  input  logic                           rst,
  input  sts_pkg::cfg_t                  cfg,
  input  sts_pkg::cmd_t                  cmd,
  output sts_pkg::stat_t                 stat,
  input  logic                           in_opcode,
  input  logic                           in_first_pass,
  input  logic [sts_pkg::LEVEL_BITS-1:0] in_measured_level,
  input  logic                           in_model_failed,
  output logic                           out_valid,
  input  logic                           out_ready,
  output sts_pkg::status_t               out_status,
  output logic [sts_pkg::LEVEL_BITS-1:0] out_stimulus_level,
  output logic [sts_pkg::ERR_BITS-1:0]   out_best_error
);

  localparam int LB = sts_pkg::LEVEL_BITS;
  localparam int MB = sts_pkg::MAG_BITS;
  localparam int PB = sts_pkg::PROD_BITS;
  localparam int QB = sts_pkg::QUOT_BITS;
  localparam int CB = sts_pkg::CNT_BITS;

  // latched item
  logic          opcode, first_pass, model_failed;
  logic [LB-1:0] meas;

  // search state
  sts_pkg::phase_t phase;
  logic [LB-1:0]   prev_in, cur_in, cur_out, prev_out, best_in, best_out;
  logic [MB-1:0]   best_err;
  logic [sts_pkg::ITER_BITS-1:0] step_count;

  // arithmetic unit
  logic [MB-1:0] op_a, op_d;
  logic [6:0]    op_c;
  logic [MB-1:0] mul_hi, mul_lo;
  logic [MB-1:0] rem;
  logic [QB-1:0] div_lo, quot;
  logic          big;
  logic [CB-1:0] cnt;

  // derived values
  logic signed [MB-1:0] diff, dx, dy;
  logic [MB-1:0]        aerr, dx_mag, dy_mag;
  logic                 neg, neg_flat;
  logic [MB:0]          mul_sum;
  logic [PB-1:0]        num;
  logic [QB-1:0]        rem_sh;
  logic                 rem_ge;
  logic                 rnd;
  logic [QB:0]          q_rnd;
  logic [MB-1:0]        q_step;
  logic signed [QB-1:0] next_lvl, scaled;
  logic [LB-1:0]        step_lvl, begin_lvl;
  logic                 better, give_up;
  logic [LB-1:0]        best_in_n, best_out_n;
  logic [MB-1:0]        best_err_n;
  logic [sts_pkg::ITER_BITS-1:0] step_n, iter_lim;

  // differences and errors of the present measurement
  always_comb begin
    diff   = $signed({cfg.target_level[LB-1], cfg.target_level}) -
             $signed({meas[LB-1], meas});
    dx     = $signed({cur_in[LB-1], cur_in}) - $signed({prev_in[LB-1], prev_in});
    dy     = $signed({meas[LB-1], meas}) - $signed({cur_out[LB-1], cur_out});
    aerr   = diff[MB-1] ? MB'(-diff) : MB'(diff);
    dx_mag = dx[MB-1] ? MB'(-dx) : MB'(dx);
    dy_mag = dy[MB-1] ? MB'(-dy) : MB'(dy);
    neg_flat = diff[MB-1] ^ dx[MB-1];
    neg      = neg_flat ^ dy[MB-1];
  end

  // one multiplier bit, the bias add and one quotient bit
  always_comb begin
    mul_sum = {1'b0, mul_hi} + (mul_lo[0] ? {1'b0, op_a} : '0);
    num     = {mul_hi, mul_lo} + PB'(op_c);
    rem_sh  = {rem, div_lo[QB-1]};
    rem_ge  = rem_sh >= {1'b0, op_d};
  end

  // secant step from the quotient, rounded and limited, and the scaled start level
  always_comb begin
    rnd    = {rem, 1'b0} >= {1'b0, op_d};
    q_rnd  = {1'b0, quot} + (QB+1)'(rnd);
    if (dx_mag == '0) q_step = '0;
    else if (dy_mag == '0) q_step = sts_pkg::STEP_LIMIT;
    else if (big || q_rnd > (QB+1)'(sts_pkg::STEP_LIMIT)) q_step = sts_pkg::STEP_LIMIT;
    else q_step = q_rnd[MB-1:0];
    if ((dy_mag == '0) ? neg_flat : neg)
      next_lvl = $signed({{(QB-LB){cur_in[LB-1]}}, cur_in}) - $signed({1'b0, q_step});
    else
      next_lvl = $signed({{(QB-LB){cur_in[LB-1]}}, cur_in}) + $signed({1'b0, q_step});
    step_lvl = sts_pkg::sat_level(next_lvl);
    scaled   = prev_in[LB-1] ? -$signed(quot) : $signed(quot);
    begin_lvl = sts_pkg::sat_level(scaled);
  end

  // best point and iteration limit
  always_comb begin
    better     = aerr < best_err;
    best_err_n = better ? aerr : best_err;
    best_in_n  = better ? cur_in : best_in;
    best_out_n = better ? meas : best_out;
    step_n     = step_count + 1'b1;
    iter_lim   = (cfg.max_iterations == '0) ? sts_pkg::ITER_BITS'(1) : cfg.max_iterations;
    give_up    = step_n >= iter_lim;
  end

  // status towards the controller
  always_comb begin
    stat.opcode       = opcode;
    stat.first_pass   = first_pass;
    stat.model_failed = model_failed;
    stat.acc_zero     = (cfg.target_accuracy == '0);
    stat.phase        = phase;
    stat.found        = aerr <= {2'b0, cfg.target_accuracy};
    stat.dx_zero      = (dx_mag == '0);
    stat.dy_zero      = (dy_mag == '0);
    stat.mul_done     = (cnt == CB'(sts_pkg::MUL_STEPS - 1));
    stat.div_done     = (cnt == CB'(sts_pkg::DIV_STEPS - 1));
    stat.out_free     = !out_valid || out_ready;
  end

  // item latch
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      opcode       <= in_opcode;
      first_pass   <= in_first_pass;
      meas         <= in_measured_level;
      model_failed <= in_model_failed;
    end
  end

  // multiplier and divider sequencing
  always_ff @(posedge clk) begin
    if (cmd.init_mul) begin
      cnt    <= '0;
      mul_hi <= '0;
      if (cmd.kind == sts_pkg::K_STEP) begin
        op_a   <= aerr;
        mul_lo <= dx_mag;
        op_c   <= '0;
        op_d   <= dy_mag;
      end else begin
        op_a   <= prev_in[LB-1] ? MB'(-$signed({1'b1, prev_in})) : {1'b0, prev_in};
        mul_lo <= MB'(sts_pkg::SCALE_MUL);
        op_c   <= sts_pkg::SCALE_BIAS;
        op_d   <= MB'(sts_pkg::SCALE_DIV);
      end
    end else if (cmd.mul_step) begin
      cnt    <= cnt + 1'b1;
      mul_hi <= mul_sum[MB:1];
      mul_lo <= {mul_sum[0], mul_lo[MB-1:1]};
    end else if (cmd.add) begin
      cnt    <= '0;
      big    <= {1'b0, num[PB-1:QB]} >= op_d;
      rem    <= {1'b0, num[PB-1:QB]};
      div_lo <= num[QB-1:0];
      quot   <= '0;
    end else if (cmd.div_step) begin
      cnt    <= cnt + 1'b1;
      rem    <= rem_ge ? MB'(rem_sh - {1'b0, op_d}) : rem_sh[MB-1:0];
      div_lo <= {div_lo[QB-2:0], 1'b0};
      quot   <= {quot[QB-2:0], rem_ge};
    end
  end

  // search state update and result at commit
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= sts_pkg::PH_IDLE;
      prev_in    <= '0;
      cur_in     <= '0;
      cur_out    <= '0;
      prev_out   <= '0;
      best_err   <= '1;
      best_in    <= '0;
      best_out   <= '0;
      step_count <= '0;
      out_valid  <= 1'b0;
    end else if (cmd.commit) begin
      out_valid      <= 1'b1;
      out_best_error <= '0;
      unique case (cmd.kind)
        sts_pkg::K_ERR: begin
          phase              <= sts_pkg::PH_IDLE;
          out_status         <= sts_pkg::ST_ERROR;
          out_stimulus_level <= '0;
        end
        sts_pkg::K_FIRST: begin
          prev_in            <= cfg.initial_guess;
          phase              <= sts_pkg::PH_FIRST;
          out_status         <= sts_pkg::ST_REQUEST;
          out_stimulus_level <= cfg.initial_guess;
        end
        sts_pkg::K_BEGIN, sts_pkg::K_BEGIN_MEAS: begin
          if (cmd.kind == sts_pkg::K_BEGIN_MEAS) cur_out <= meas;
          cur_in             <= begin_lvl;
          step_count         <= '0;
          best_err           <= '1;
          phase              <= sts_pkg::PH_SEARCH;
          out_status         <= sts_pkg::ST_REQUEST;
          out_stimulus_level <= begin_lvl;
        end
        sts_pkg::K_FOUND: begin
          prev_out           <= cur_out;
          cur_out            <= meas;
          phase              <= sts_pkg::PH_IDLE;
          out_status         <= sts_pkg::ST_FOUND;
          out_stimulus_level <= cur_in;
        end
        sts_pkg::K_STEP: begin
          prev_out   <= cur_out;
          best_err   <= best_err_n;
          best_in    <= best_in_n;
          best_out   <= best_out_n;
          step_count <= step_n;
          cur_in     <= step_lvl;
          if (give_up) begin
            prev_in            <= best_in_n;
            cur_out            <= best_out_n;
            phase              <= sts_pkg::PH_IDLE;
            out_status         <= sts_pkg::ST_GAVE_UP;
            out_stimulus_level <= best_in_n;
            out_best_error     <= (best_err_n[MB-1:sts_pkg::ERR_BITS] != '0) ?
                                  '1 : best_err_n[sts_pkg::ERR_BITS-1:0];
          end else begin
            prev_in            <= cur_in;
            cur_out            <= meas;
            out_status         <= sts_pkg::ST_REQUEST;
            out_stimulus_level <= step_lvl;
          end
        end
        default: begin
          phase              <= sts_pkg::PH_IDLE;
          out_status         <= sts_pkg::ST_ERROR;
          out_stimulus_level <= '0;
        end
      endcase
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// ===== sv/secant_threshold_search.sv =====
// Secant threshold search. A start request either asks for the initial
// guess first or goes straight to a request at 1.01 times the previous
// level (or gives an error when the target accuracy is zero); each
// measured-response request then yields one result: the next level to
// measure, found, gave up with the best level, or error. A request that
// needs a secant step or the 1.01 scaling runs one shared shift-add
// multiplier and a restoring divider in turn, plus decode, bias add and
// commit; other requests go from decode straight to commit. One request
// is worked at a time; a new one is accepted while the previous result
// still waits in the output register. Levels are signed Q16.16 dB.
// top level: configuration registers, controller and datapath; depends on
// sts_pkg, sts_ctrl and sts_dpath
module secant_threshold_search (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [sts_pkg::ADDR_BITS-1:0]   paddr,
  input  logic [sts_pkg::DATA_BITS-1:0]   pwdata,
  output logic [sts_pkg::DATA_BITS-1:0]   prdata,
  output logic                            pready,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // [0] first_pass, [32:1] measured_level, [33] model_failed, rest zero
  input  logic [8*sts_pkg::IN_BYTES-1:0]  s_axis_tdata,
  // [0] opcode
  input  logic                            s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [31:0] stimulus_level, [62:32] best_error, [63] zero
  output logic [8*sts_pkg::OUT_BYTES-1:0] m_axis_tdata,
  // [1:0] status
  output logic [1:0]                      m_axis_tuser
);

  localparam int LB = sts_pkg::LEVEL_BITS;

  sts_pkg::cfg_t      cfg;
  sts_pkg::cmd_t      cmd;
  sts_pkg::stat_t     stat;
  sts_pkg::reg_idx_t  reg_idx;
  sts_pkg::status_t   status;
  logic [LB-1:0]      stim;
  logic [sts_pkg::ERR_BITS-1:0] best_error;

  assign pready  = 1'b1;
  assign reg_idx = sts_pkg::reg_idx_t'(paddr[3:2]);

  // configuration register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.target_level    <= '0;
      cfg.target_accuracy <= sts_pkg::ACC_RESET;
      cfg.max_iterations  <= sts_pkg::ITER_RESET;
      cfg.initial_guess   <= sts_pkg::GUESS_RESET;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_idx)
        sts_pkg::REG_TARGET_LEVEL: cfg.target_level <= pwdata[LB-1:0];
        sts_pkg::REG_TARGET_ACC:   cfg.target_accuracy <= pwdata[sts_pkg::ERR_BITS-1:0];
        sts_pkg::REG_MAX_ITER:     cfg.max_iterations <= pwdata[sts_pkg::ITER_BITS-1:0];
        sts_pkg::REG_INIT_GUESS:   cfg.initial_guess <= pwdata[LB-1:0];
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    unique case (reg_idx)
      sts_pkg::REG_TARGET_LEVEL: prdata = cfg.target_level;
      sts_pkg::REG_TARGET_ACC:   prdata = {1'b0, cfg.target_accuracy};
      sts_pkg::REG_MAX_ITER:     prdata = {{(sts_pkg::DATA_BITS-sts_pkg::ITER_BITS){1'b0}},
                                           cfg.max_iterations};
      sts_pkg::REG_INIT_GUESS:   prdata = cfg.initial_guess;
      default:                   prdata = '0;
    endcase
  end

  sts_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  sts_dpath u_dpath (
    .clk                (clk),
    .rst                (rst),
    .cfg                (cfg),
    .cmd                (cmd),
    .stat               (stat),
    .in_opcode          (s_axis_tuser),
    .in_first_pass      (s_axis_tdata[0]),
    .in_measured_level  (s_axis_tdata[LB:1]),
    .in_model_failed    (s_axis_tdata[LB+1]),
    .out_valid          (m_axis_tvalid),
    .out_ready          (m_axis_tready),
    .out_status         (status),
    .out_stimulus_level (stim),
    .out_best_error     (best_error)
  );

  assign m_axis_tuser = status;
  assign m_axis_tdata = {1'b0, best_error, stim};

endmodule

// ===== sv/sts_checker.sv =====
// port-level checks of the secant threshold search, bound to the top level
// depends on sts_pkg
module sts_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [8*sts_pkg::OUT_BYTES-1:0] m_axis_tdata,
  input logic [1:0]                      m_axis_tuser
);

  // no result straight after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) &&
                                        $stable(m_axis_tuser))
    else $error("stalled result changed");

  // an error carries a zero level
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser == sts_pkg::ST_ERROR |-> m_axis_tdata[31:0] == '0)
    else $error("error result with nonzero level");

  // best error shows only on give-up
  a_best_err: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser != sts_pkg::ST_GAVE_UP |-> m_axis_tdata[62:32] == '0)
    else $error("best error outside give-up");

endmodule

bind secant_threshold_search sts_checker u_sts_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

// ===== test/secant_threshold_search_tb.sv =====
// self-checking testbench for the secant threshold search block
// needs sts_pkg and secant_threshold_search; an in-bench predictor checks every result
module secant_threshold_search_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sts_pkg::*;

  typedef struct {
    status_t     st;
    logic [31:0] lvl;
    logic [30:0] err;
  } search_result_t;

  localparam longint LVL_HI = 64'sd2147483647;
  localparam longint LVL_LO = -64'sd2147483648;
  localparam int STALL_LIMIT = 5000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ADDR_BITS-1:0] paddr = '0;
  logic [DATA_BITS-1:0] pwdata = '0;
  logic [DATA_BITS-1:0] prdata;
  logic pready;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  // [0] first_pass, [32:1] measured_level, [33] model_failed, rest zero
  logic [8*IN_BYTES-1:0] s_axis_tdata = '0;
  // [0] opcode
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  // [31:0] stimulus_level, [62:32] best_error, [63] zero
  logic [8*OUT_BYTES-1:0] m_axis_tdata;
  // [1:0] status
  logic [1:0] m_axis_tuser;

  secant_threshold_search dut (.*);

  always #1 clk = ~clk;

  // predictor state and configuration copy
  longint      cfg_target, cfg_guess;
  logic [30:0] cfg_acc;
  logic [9:0]  cfg_iters;
  phase_t      ph;
  longint      prev_in, cur_in, cur_out, prev_out, best_in, best_out;
  logic [63:0] best_err;
  logic [9:0]  steps;

  search_result_t expected_q[$];
  search_result_t last_res;
  int  fail_cnt = 0;
  int  item_cnt = 0;
  int  result_cnt = 0;
  int  found_cnt = 0, gaveup_cnt = 0, error_cnt = 0;
  int  quiet_cycles = 0;
  bit  calm = 1'b0;

  // stimulus model: response = sign * (level >>> shift) + offset
  int     resp_shift;
  bit     resp_neg;
  longint resp_offset;
  bit     resp_flat;

  function automatic longint clamp_level(longint x);
    return x > LVL_HI ? LVL_HI : (x < LVL_LO ? LVL_LO : x);
  endfunction

  function automatic longint scale_101(longint x);
    longint m;
    m = ((x < 0 ? -x : x) * 101 + 50) / 100;
    return clamp_level(x < 0 ? -m : m);
  endfunction

  function automatic search_result_t make_res(status_t st, longint lvl, logic [63:0] err);
    search_result_t r;
    r.st  = st;
    r.lvl = lvl[31:0];
    r.err = (err > 64'h7FFFFFFF) ? 31'h7FFFFFFF : err[30:0];
    return r;
  endfunction

  function automatic search_result_t begin_search();
    cur_in   = scale_101(prev_in);
    steps    = '0;
    best_err = '1;
    ph       = PH_SEARCH;
    return make_res(ST_REQUEST, cur_in, 0);
  endfunction

  // one search request in, one predicted result out
  function automatic search_result_t search_step(opcode_t op, bit fp, logic [31:0] meas_raw,
                                                 bit failed);
    longint meas, diff, dx, dy, nxt, q;
    logic [63:0] aerr, adx, ady;
    logic [127:0] prod, quo, rem;
    bit neg;
    meas = longint'($signed(meas_raw));
    if (op == OP_START) begin
      if (cfg_acc == 0) begin
        ph = PH_IDLE;
        return make_res(ST_ERROR, 0, 0);
      end
      if (fp) begin
        prev_in = cfg_guess;
        ph = PH_FIRST;
        return make_res(ST_REQUEST, prev_in, 0);
      end
      return begin_search();
    end
    if (ph == PH_IDLE) return make_res(ST_ERROR, 0, 0);
    if (failed) begin
      ph = PH_IDLE;
      return make_res(ST_ERROR, 0, 0);
    end
    if (ph == PH_FIRST) begin
      cur_out = meas;
      return begin_search();
    end
    prev_out = cur_out;
    cur_out  = meas;
    diff = cfg_target - meas;
    aerr = diff < 0 ? -diff : diff;
    if (aerr <= {33'd0, cfg_acc}) begin
      ph = PH_IDLE;
      return make_res(ST_FOUND, cur_in, 0);
    end
    if (aerr < best_err) begin
      best_err = aerr;
      best_in  = cur_in;
      best_out = meas;
    end
    dx  = cur_in - prev_in;
    dy  = cur_out - prev_out;
    adx = dx < 0 ? -dx : dx;
    ady = dy < 0 ? -dy : dy;
    neg = ((diff < 0) != (dx < 0)) != (dy < 0);
    if (dx == 0) q = 0;
    else if (dy == 0) begin
      q = 64'sd4294967296;
      neg = (diff < 0) != (dx < 0);
    end else begin
      prod = {64'd0, aerr} * {64'd0, adx};
      quo  = prod / {64'd0, ady};
      rem  = prod % {64'd0, ady};
      if (rem >= {64'd0, ady} - rem) quo = quo + 1;
      q = (quo > 128'd4294967296) ? 64'sd4294967296 : longint'(quo[63:0]);
    end
    nxt = neg ? cur_in - q : cur_in + q;
    prev_in = cur_in;
    cur_in  = clamp_level(nxt);
    steps   = steps + 10'd1;
    if (steps >= ((cfg_iters == 0) ? 10'd1 : cfg_iters)) begin
      prev_in = best_in;
      cur_out = best_out;
      ph = PH_IDLE;
      return make_res(ST_GAVE_UP, best_in, best_err);
    end
    return make_res(ST_REQUEST, cur_in, 0);
  endfunction

  // send one request and record its expected result on acceptance
  task automatic send_req(opcode_t op, bit fp, logic [31:0] meas, bit failed);
    if (!calm && $urandom_range(99) < 33) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {6'd0, failed, meas, fp};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    last_res = search_step(op, fp, meas, failed);
    expected_q.push_back(last_res);
    item_cnt++;
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  // register write: setup then access cycle, block must be idle
  task automatic write_reg(reg_idx_t idx, logic [31:0] val);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= ADDR_BITS'(4 * int'(idx));
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_TARGET_LEVEL: cfg_target = longint'($signed(val));
      REG_TARGET_ACC:   cfg_acc = val[30:0];
      REG_MAX_ITER:     cfg_iters = val[9:0];
      REG_INIT_GUESS:   cfg_guess = longint'($signed(val));
      default: ;
    endcase
  endtask

  task automatic set_config(logic [31:0] tgt, logic [31:0] acc, logic [31:0] iters,
                            logic [31:0] guess);
    wait_idle();
    write_reg(REG_TARGET_LEVEL, tgt);
    write_reg(REG_TARGET_ACC, acc);
    write_reg(REG_MAX_ITER, iters);
    write_reg(REG_INIT_GUESS, guess);
  endtask

  function automatic logic [31:0] model_response(logic [31:0] lvl);
    longint r;
    r = longint'($signed(lvl)) >>> resp_shift;
    if (resp_neg) r = -r;
    r = r + resp_offset + $urandom_range(0, 3) - 1;
    if (resp_flat) r = (r >>> 20) <<< 20;
    return 32'(clamp_level(r));
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(5))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return 32'hFFFFFFFF;
      3: return 32'h00000000;
      default: return $urandom();
    endcase
  endfunction

  // a well-formed search with model responses, and occasional disruption
  task automatic run_search(bit may_break);
    int n;
    send_req(OP_START, 1'($urandom_range(1)), rand_word(), 1'($urandom_range(1)));
    n = 0;
    while (last_res.st == ST_REQUEST && n < 1100 && item_cnt < 1650) begin
      if (may_break && $urandom_range(99) < 2)
        send_req(OP_MEASURE, 1'b0, rand_word(), 1'b1);
      else if (may_break && $urandom_range(99) < 2)
        send_req(OP_START, 1'($urandom_range(1)), rand_word(), 1'b0);
      else if (may_break && $urandom_range(99) < 3)
        send_req(OP_MEASURE, 1'($urandom_range(1)), rand_word(), 1'b0);
      else
        send_req(OP_MEASURE, 1'($urandom_range(1)), model_response(last_res.lvl), 1'b0);
      n++;
    end
  endtask

  task automatic pick_model();
    resp_shift  = $urandom_range(0, 3);
    resp_neg    = $urandom_range(3) == 0;
    resp_offset = longint'($signed($urandom())) >>> $urandom_range(0, 8);
    resp_flat   = $urandom_range(9) == 0;
  endtask

  // error paths: zero accuracy, measurement while idle, model failure
  task automatic test_error_paths();
    send_req(OP_MEASURE, 1'b0, 32'h12345678, 1'b0);
    set_config(32'h00100000, 32'd0, 32'd5, 32'h00640000);
    send_req(OP_START, 1'b1, 32'd0, 1'b0);
    send_req(OP_START, 1'b0, 32'd0, 1'b0);
    set_config(32'h00100000, 32'd6554, 32'd5, 32'h00640000);
    send_req(OP_START, 1'b1, 32'd0, 1'b0);
    send_req(OP_MEASURE, 1'b0, 32'h00200000, 1'b1);
    send_req(OP_MEASURE, 1'b0, 32'h00200000, 1'b0);
  endtask

  // extreme levels, flat response, zero iterations, give-up and resume
  task automatic test_edges();
    set_config(32'h7FFFFFFF, 32'd1, 32'd0, 32'h80000000);
    send_req(OP_START, 1'b1, 32'd0, 1'b0);
    send_req(OP_MEASURE, 1'b0, 32'h80000000, 1'b0);
    send_req(OP_MEASURE, 1'b0, 32'h80000000, 1'b0);
    set_config(32'h80000000, 32'd1, 32'd3, 32'h7FFFFFFF);
    send_req(OP_START, 1'b1, 32'd0, 1'b0);
    send_req(OP_MEASURE, 1'b0, 32'h7FFFFFFF, 1'b0);
    send_req(OP_MEASURE, 1'b0, 32'h7FFFFFFF, 1'b0);
    send_req(OP_MEASURE, 1'b0, 32'h7FFFFFFF, 1'b0);
    send_req(OP_START, 1'b1, 32'd0, 1'b0);
    send_req(OP_START, 1'b0, 32'd0, 1'b0);
    send_req(OP_MEASURE, 1'b0, 32'h00000000, 1'b0);
    send_req(OP_MEASURE, 1'b0, 32'h00010000, 1'b0);
    send_req(OP_MEASURE, 1'b0, 32'h00020000, 1'b0);
    send_req(OP_START, 1'b0, 32'd0, 1'b0);
    set_config(32'd0, 32'h7FFFFFFF, 32'd1023, 32'd0);
    send_req(OP_START, 1'b1, 32'd0, 1'b0);
    send_req(OP_MEASURE, 1'b0, 32'h80000000, 1'b0);
    send_req(OP_MEASURE, 1'b0, 32'h00000000, 1'b0);
  endtask

  // random searches over several settings, with one calm stretch
  task automatic test_random_searches();
    int k;
    k = 0;
    while (item_cnt < 1650) begin
      if (k % 8 == 0)
        set_config(rand_word() >>> $urandom_range(0, 12),
                   ($urandom_range(19) == 0) ? 32'd0 : ($urandom() >> $urandom_range(9, 31)),
                   ($urandom_range(29) == 0) ? 32'd1023 : $urandom_range(0, 30),
                   rand_word() >>> $urandom_range(0, 10));
      calm = (k >= 40 && k < 70);
      pick_model();
      run_search(1'b1);
      if ($urandom_range(9) == 0)
        send_req(OP_MEASURE, 1'($urandom_range(1)), rand_word(), 1'b0);
      k++;
    end
    calm = 1'b0;
  endtask

  // receiver back-pressure
  always @(posedge clk) m_axis_tready <= calm || ($urandom_range(99) >= 33);

  // compare each result with the oldest expectation
  always @(posedge clk) begin
    search_result_t e;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      result_cnt++;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result status %0d level %h err %h", $time,
                 m_axis_tuser, m_axis_tdata[31:0], m_axis_tdata[62:32]);
        fail_cnt++;
      end else begin
        e = expected_q.pop_front();
        case (e.st)
          ST_FOUND:   found_cnt++;
          ST_GAVE_UP: gaveup_cnt++;
          ST_ERROR:   error_cnt++;
          default: ;
        endcase
        if (m_axis_tuser != e.st || m_axis_tdata[31:0] != e.lvl
            || m_axis_tdata[62:32] != e.err || m_axis_tdata[63] != 1'b0) begin
          $display("%0t: mismatch expected st %0d lvl %h err %h, got st %0d lvl %h err %h",
                   $time, e.st, e.lvl, e.err, m_axis_tuser, m_axis_tdata[31:0],
                   m_axis_tdata[62:32]);
          fail_cnt++;
        end
      end
    end
  end

  // watchdog on cycles with no request or result moving
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > STALL_LIMIT) begin
      $display("%0t: timeout, %0d results outstanding", $time, expected_q.size());
      $display("secant_threshold_search_tb NOT OK");
      $finish;
    end
  end

  initial begin
    cfg_target = 0;
    cfg_acc = 31'd6554;
    cfg_iters = 10'd20;
    cfg_guess = 64'sd6553600;
    ph = PH_IDLE;
    prev_in = 0; cur_in = 0; cur_out = 0; prev_out = 0;
    best_in = 0; best_out = 0;
    best_err = '1;
    steps = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_error_paths();
    test_edges();
    test_random_searches();
    wait_idle();
    $display("%0d requests, %0d results: %0d found, %0d gave up, %0d errors",
             item_cnt, result_cnt, found_cnt, gaveup_cnt, error_cnt);
    $display("covered zero accuracy, idle and failed measurements, flat and extreme levels");
    if (fail_cnt == 0) begin
      $display("secant_threshold_search_tb OK");
    end else begin
      $display("secant_threshold_search_tb NOT OK");
    end
    $finish;
  end

endmodule
